/* hdl/hbd_pkg.sv */
package hbd_pkg;

	localparam int CODE_W = 16;
	localparam int LEN_W = 5;
	localparam int SYM_W = 8;
	localparam int INDEX_W = 8;
	localparam int ENTRY_W = CODE_W + LEN_W + SYM_W;

	localparam int DEF_TABLE_ENTRIES = 256;
	localparam int DEF_MAX_CODE_LEN = 16;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  length;
		logic [SYM_W-1:0]  symbol;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

endpackage

/* hdl/hbd_ram.sv */
module hbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/huffman_bit_decoder.sv */
// Prefix-code bit decoder with a loaded code table. A request with mode low writes one
// table slot in the cycle it is accepted and never raises busy; a slot index at or beyond
// TABLE_ENTRIES is ignored. A request with mode high appends one bit to the partial code
// and then scans the table one slot per cycle through a single comparator, with busy
// high until the scan has passed every slot, or until an earlier slot matches. The table
// read port and that comparator set this pace. A result (symbol, or overflow with a zero
// symbol) is shown for exactly one cycle with result_valid and must be taken then, as the
// receiver cannot stall the block. Reset empties the table at once through per-slot
// valid bits.
module huffman_bit_decoder #(
	parameter int TABLE_ENTRIES = hbd_pkg::DEF_TABLE_ENTRIES,
	parameter int MAX_CODE_LEN = hbd_pkg::DEF_MAX_CODE_LEN
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        mode,
	input  logic [hbd_pkg::INDEX_W-1:0] entry_index,
	input  logic [hbd_pkg::CODE_W-1:0]  entry_code,
	input  logic [hbd_pkg::LEN_W-1:0]   entry_length,
	input  logic [hbd_pkg::SYM_W-1:0]   entry_symbol,
	input  logic                        stream_bit,
	output logic                        result_valid,
	output logic [hbd_pkg::SYM_W-1:0]   symbol,
	output logic                        overflow
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int PL_W = $clog2(MAX_CODE_LEN + 1);

	hbd_pkg::state_t state_q, state_d;
	hbd_pkg::entry_t wr_ent, rd_ent;

	logic [IDX_W-1:0]         idx_q;
	logic                     rd_s1;
	logic                     vld_s1;
	logic [TABLE_ENTRIES-1:0] vld_q;
	logic [MAX_CODE_LEN-1:0]  pcode_q;
	logic [PL_W-1:0]          plen_q;
	logic                     result_valid_q;
	logic                     overflow_q;
	logic [hbd_pkg::SYM_W-1:0] symbol_q;

	logic accept, dec_acc, ld_acc, wr_en, in_range;
	logic issue, hit, fin, is_last, plen_full, len_eq, code_eq, emit;
	logic [MAX_CODE_LEN+hbd_pkg::CODE_W-1:0] code_wide;
	logic [MAX_CODE_LEN-1:0] code_ext, len_mask;

	assign busy = (state_q != hbd_pkg::ST_IDLE);
	assign accept = start & ~busy;
	assign dec_acc = accept & (mode == hbd_pkg::MODE_DECODE);
	assign ld_acc = accept & (mode == hbd_pkg::MODE_LOAD);
	assign in_range = (9'(entry_index) < 9'(TABLE_ENTRIES));
	assign wr_en = ld_acc & in_range;

	assign wr_ent.code = entry_code;
	assign wr_ent.length = entry_length;
	assign wr_ent.symbol = entry_symbol;

	hbd_ram #(
		.WIDTH(hbd_pkg::ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (entry_index[IDX_W-1:0]),
		.wdata (wr_ent),
		.re    (issue),
		.raddr (idx_q),
		.rdata (rd_ent)
	);

	always_comb begin
		code_wide = {{MAX_CODE_LEN{1'b0}}, rd_ent.code};
		code_ext = code_wide[MAX_CODE_LEN-1:0];
		for (int j = 0; j < MAX_CODE_LEN; j++) begin
			len_mask[j] = (j < int'(rd_ent.length));
		end
	end

	assign len_eq = (32'(rd_ent.length) == 32'(plen_q));
	assign code_eq = ((code_ext & len_mask) == pcode_q);
	assign is_last = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
	assign plen_full = (plen_q == PL_W'(MAX_CODE_LEN));
	assign hit = busy & rd_s1 & vld_s1 & len_eq & code_eq;
	assign emit = hit | (fin & plen_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hbd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		issue = 1'b0;
		fin = 1'b0;
		case (state_q)
			hbd_pkg::ST_IDLE: begin
				if (dec_acc) begin
					state_d = hbd_pkg::ST_SCAN;
				end
			end
			hbd_pkg::ST_SCAN: begin
				issue = 1'b1;
				if (hit) begin
					state_d = hbd_pkg::ST_IDLE;
				end else if (is_last) begin
					state_d = hbd_pkg::ST_DRAIN;
				end
			end
			hbd_pkg::ST_DRAIN: begin
				fin = ~hit;
				state_d = hbd_pkg::ST_IDLE;
			end
			default: begin
				state_d = hbd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rd_s1 <= 1'b0;
			vld_s1 <= 1'b0;
			vld_q <= '0;
			pcode_q <= '0;
			plen_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (dec_acc) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			rd_s1 <= issue;
			vld_s1 <= vld_q[idx_q];
			if (wr_en) begin
				vld_q[entry_index[IDX_W-1:0]] <= 1'b1;
			end
			if (dec_acc) begin
				pcode_q <= {pcode_q[MAX_CODE_LEN-2:0], stream_bit};
				plen_q <= plen_q + 1'b1;
			end else if (emit) begin
				pcode_q <= '0;
				plen_q <= '0;
			end
			result_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			symbol_q <= rd_ent.symbol;
			overflow_q <= 1'b0;
		end else if (fin) begin
			symbol_q <= '0;
			overflow_q <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign symbol = symbol_q;
	assign overflow = overflow_q;

`ifndef SYNTH
	a_scan_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (plen_q != '0))
		else $error("scan running with an empty partial code");

	a_result_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |=> !result_valid_q)
		else $error("two results in consecutive cycles");

	a_scan_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dec_acc |=> (state_q == hbd_pkg::ST_SCAN) && (idx_q == '0))
		else $error("decode request did not start a scan at slot zero");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && overflow_q) |-> ($past(plen_q) == PL_W'(MAX_CODE_LEN)))
		else $error("overflow reported before the partial code was full");

	a_load_keeps_partial: assert property (@(posedge clk) disable iff (!arst_n)
		ld_acc |=> $stable(plen_q) && $stable(pcode_q))
		else $error("table load disturbed the partial code");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

	import hbd_pkg::*;

	localparam int SLOTS = DEF_TABLE_ENTRIES;
	localparam int LONGEST = DEF_MAX_CODE_LEN;
	localparam int DIRECTED = 24;
	localparam int RANDOM_ITEMS = 800;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 300;

	typedef struct {
		logic               op;
		logic [INDEX_W-1:0] slot;
		logic [CODE_W-1:0]  code;
		logic [LEN_W-1:0]   len;
		logic [SYM_W-1:0]   sym;
		logic               bit_in;
	} request_t;

	typedef struct {
		logic [SYM_W-1:0] sym;
		logic             ovf;
	} decoded_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               mode = MODE_LOAD;
	logic [INDEX_W-1:0] entry_index = '0;
	logic [CODE_W-1:0]  entry_code = '0;
	logic [LEN_W-1:0]   entry_length = '0;
	logic [SYM_W-1:0]   entry_symbol = '0;
	logic               stream_bit = 1'b0;
	logic               busy;
	logic               result_valid;
	logic [SYM_W-1:0]   symbol;
	logic               overflow;

	request_t pending[$];
	decoded_t decoded_due[$];
	request_t on_bus;

	bit [CODE_W-1:0] book_code [SLOTS];
	bit [LEN_W-1:0]  book_len [SLOTS];
	bit [SYM_W-1:0]  book_sym [SLOTS];
	bit [CODE_W-1:0] part_code;
	int              part_len;

	bit [SLOTS-1:0] slot_in_use;
	bit [SLOTS-1:0] slot_taken;

	int loads_taken;
	int decodes_taken;
	int symbols_seen;
	int overflows_seen;
	int mismatches;
	int quiet_cycles;
	int burst_left;
	int gap_left;

	huffman_bit_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.entry_index(entry_index),
		.entry_code(entry_code),
		.entry_length(entry_length),
		.entry_symbol(entry_symbol),
		.stream_bit(stream_bit),
		.result_valid(result_valid),
		.symbol(symbol),
		.overflow(overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("MISMATCH at %0t ns: %s", $realtime, msg);
	endtask

	function automatic void push_load(logic [INDEX_W-1:0] s, logic [CODE_W-1:0] c,
			logic [LEN_W-1:0] l, logic [SYM_W-1:0] y);
		request_t r;
		r.op = MODE_LOAD;
		r.slot = s;
		r.code = c;
		r.len = l;
		r.sym = y;
		r.bit_in = 1'($urandom_range(0, 1));
		pending.push_back(r);
	endfunction

	function automatic void push_bit(logic b);
		request_t r;
		r.op = MODE_DECODE;
		r.slot = INDEX_W'($urandom);
		r.code = CODE_W'($urandom);
		r.len = LEN_W'($urandom);
		r.sym = SYM_W'($urandom);
		r.bit_in = b;
		pending.push_back(r);
	endfunction

	function automatic int free_slot();
		int s;
		do
			s = $urandom_range(0, SLOTS - 1);
		while (slot_taken[s]);
		slot_taken[s] = 1'b1;
		slot_in_use[s] = 1'b1;
		return s;
	endfunction

	// Mirrors the block: a load writes a slot, a decode shifts in one bit and
	// looks for the lowest matching slot, or flags an overflow at full length.
	function automatic void apply_request(request_t r);
		logic [CODE_W-1:0] mask;
		decoded_t res;
		bit hit;
		int k;
		hit = 1'b0;
		if (r.op == MODE_LOAD) begin
			book_code[r.slot] = r.code;
			book_len[r.slot] = r.len;
			book_sym[r.slot] = r.sym;
			loads_taken++;
		end else begin
			decodes_taken++;
			part_code = {part_code[CODE_W-2:0], r.bit_in};
			part_len++;
			for (k = 0; k < SLOTS && !hit; k++) begin
				mask = CODE_W'((32'd1 << book_len[k]) - 1);
				if (book_len[k] != 0 && book_len[k] <= LONGEST && book_len[k] == part_len
						&& (book_code[k] & mask) == part_code) begin
					hit = 1'b1;
					res.sym = book_sym[k];
					res.ovf = 1'b0;
				end
			end
			if (!hit && part_len >= LONGEST) begin
				hit = 1'b1;
				res.sym = '0;
				res.ovf = 1'b1;
			end
			if (hit) begin
				decoded_due.push_back(res);
				part_code = '0;
				part_len = 0;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic take;
		if (!arst_n) begin
			start <= 1'b0;
			burst_left = $urandom_range(1, 8);
			gap_left = 0;
		end else begin
			take = start && !busy;
			if (take)
				apply_request(on_bus);
			if (take || !start) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending.size() > 0) begin
					on_bus = pending.pop_front();
					start <= 1'b1;
					mode <= on_bus.op;
					entry_index <= on_bus.slot;
					entry_code <= on_bus.code;
					entry_length <= on_bus.len;
					entry_symbol <= on_bus.sym;
					stream_bit <= on_bus.bit_in;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 4) == 0) ?
							$urandom_range(20, 60) : $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 7) == 0) ?
							$urandom_range(20, 300) : $urandom_range(1, 5);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n) begin
			if (result_valid) begin
				if (decoded_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result, symbol %02h overflow %0b",
						symbol, overflow));
				end else begin
					want = decoded_due.pop_front();
					if (symbol !== want.sym)
						report_mismatch($sformatf("symbol %02h, expected %02h",
							symbol, want.sym));
					if (overflow !== want.ovf)
						report_mismatch($sformatf("overflow %0b, expected %0b",
							overflow, want.ovf));
				end
				if (overflow === 1'b1)
					overflows_seen++;
				else
					symbols_seen++;
			end
			if (result_valid || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timed out after %0d cycles with no request or result accepted.",
					QUIET_LIMIT);
				$display("testbench failed");
				$finish;
			end
		end
	end

	initial begin
		logic [CODE_W-1:0] leaf_code [32];
		int leaf_len [32];
		logic [CODE_W-1:0] mask;
		int count, n_leaves, k, w, b, s;
		bit deep;

		// An empty table never matches, so sixteen bits run into an overflow.
		for (k = 0; k < LONGEST; k++)
			push_bit(k[0]);
		push_load(8'd1, 16'hFFFE, 5'd1, 8'hFF);
		push_load(8'd2, 16'h0000, 5'd1, 8'h11);
		push_load(8'd0, 16'hFFFF, 5'd0, 8'hEE);
		push_load(8'd7, 16'h0001, 5'd31, 8'h33);
		push_bit(1'b0);
		push_bit(1'b1);
		// The partial code must survive a load arriving between two bits.
		push_load(8'd255, 16'h0002, 5'd2, 8'h5A);
		push_bit(1'b0);

		slot_in_use = '0;
		slot_in_use[0] = 1'b1;
		slot_in_use[1] = 1'b1;
		slot_in_use[2] = 1'b1;
		slot_in_use[7] = 1'b1;
		slot_in_use[255] = 1'b1;

		while (pending.size() < DIRECTED + RANDOM_ITEMS) begin
			for (s = 0; s < SLOTS; s++)
				if (slot_in_use[s] && $urandom_range(0, 3) != 0) begin
					push_load(INDEX_W'(s), CODE_W'($urandom), '0, SYM_W'($urandom));
					slot_in_use[s] = 1'b0;
				end
			slot_taken = '0;

			// Grow a prefix-free code by splitting leaves; deep codes follow one chain.
			deep = ($urandom_range(0, 3) == 0);
			n_leaves = deep ? $urandom_range(12, LONGEST + 1) : $urandom_range(2, 12);
			leaf_code[0] = '0;
			leaf_len[0] = 0;
			count = 1;
			while (count < n_leaves) begin
				k = $urandom_range(0, count - 1);
				if (deep)
					for (w = 0; w < count; w++)
						if (leaf_len[w] > leaf_len[k])
							k = w;
				if (leaf_len[k] < LONGEST) begin
					leaf_code[count] = {leaf_code[k][CODE_W-2:0], 1'b1};
					leaf_len[count] = leaf_len[k] + 1;
					leaf_code[k] = {leaf_code[k][CODE_W-2:0], 1'b0};
					leaf_len[k]++;
					count++;
				end
			end

			for (w = 0; w < count; w++)
				if ($urandom_range(0, 7) != 0) begin
					mask = CODE_W'((32'd1 << leaf_len[w]) - 1);
					push_load(INDEX_W'(free_slot()), (CODE_W'($urandom) & ~mask) | leaf_code[w],
						LEN_W'(leaf_len[w]), SYM_W'($urandom));
				end
			if ($urandom_range(0, 4) == 0) begin
				w = $urandom_range(0, count - 1);
				push_load(INDEX_W'(free_slot()), leaf_code[w], LEN_W'(leaf_len[w]),
					SYM_W'($urandom));
			end
			if ($urandom_range(0, 3) == 0)
				push_load(INDEX_W'(free_slot()), CODE_W'($urandom),
					LEN_W'($urandom_range(LONGEST + 1, 31)), SYM_W'($urandom));

			repeat ($urandom_range(10, 40)) begin
				case ($urandom_range(0, 19))
					0, 1: push_bit(1'($urandom_range(0, 1)));
					2: push_load(INDEX_W'(free_slot()), CODE_W'($urandom),
						LEN_W'($urandom_range(LONGEST + 1, 31)), SYM_W'($urandom));
					default: begin
						w = $urandom_range(0, count - 1);
						for (b = leaf_len[w] - 1; b >= 0; b--)
							push_bit(leaf_code[w][b]);
					end
				endcase
			end
		end
		while (pending.size() > DIRECTED + RANDOM_ITEMS)
			void'(pending.pop_back());

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending.size() != 0 || start || decoded_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d table loads and %0d coded bits through the decoder.",
			loads_taken, decodes_taken);
		$display("Checked %0d decoded symbols and %0d overflows; %0d mismatches.",
			symbols_seen, overflows_seen, mismatches);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
